// ===== hw/rtl/gamma_temporal_dither_defines.svh =====
// Assertion macros shared by the gamma_temporal_dither RTL.
// Files that assert include this header; it expects clk and rst in scope.
`ifndef GAMMA_TEMPORAL_DITHER_DEFINES_SVH
`define GAMMA_TEMPORAL_DITHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gtd_pkg.sv =====
// Shared types, constants and the lightness table for gamma_temporal_dither.
// No dependencies; used by gtd_lane, gtd_merge and the top level.
package gtd_pkg;

  localparam int NUM_PIXELS  = 4096;
  localparam int RES_AW      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int IDX_W       = 12;
  localparam int IDX_EXT_W   = 17;  // holds any index and NUM_PIXELS itself
  localparam int CHAN_W      = 8;
  localparam int LUT_W       = 12;
  localparam int RES_W       = 2;
  localparam int OUT_CH_W    = LUT_W - RES_W;
  localparam int LANES       = 3;
  localparam int COLOR_W     = CHAN_W * LANES;
  localparam int PACKED_W    = OUT_CH_W * LANES;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Lane numbering follows the channel position in color_word.
  localparam int LANE_LO  = 0;
  localparam int LANE_MID = 1;
  localparam int LANE_HI  = 2;

  // mode codes
  localparam logic MODE_LO_TOP = 1'b0;
  localparam logic MODE_HI_TOP = 1'b1;

  localparam logic [LUT_W-1:0] LUT_MAX = '1;

  typedef logic [OUT_CH_W-1:0] chan_t;

  typedef struct packed {
    logic              accept;    // input beat taken this cycle
    logic              advance;   // stage 1 moves into the output register
    logic [RES_AW-1:0] rd_addr;   // residue address of the incoming beat
    logic              rd_ok;     // incoming index is inside the store
    logic              clr_we;    // clearing pass write
    logic [RES_AW-1:0] clr_addr;
  } lane_ctrl_t;

  // CIE lightness expansion, 8-bit code to 12-bit level
  localparam logic [LUT_W-1:0] LIGHT_ROM [256] = '{
    12'd0, 12'd2, 12'd4, 12'd5, 12'd7, 12'd9, 12'd11, 12'd12,
    12'd14, 12'd16, 12'd18, 12'd20, 12'd21, 12'd23, 12'd25, 12'd27,
    12'd28, 12'd30, 12'd32, 12'd34, 12'd36, 12'd37, 12'd39, 12'd41,
    12'd43, 12'd45, 12'd47, 12'd49, 12'd52, 12'd54, 12'd56, 12'd59,
    12'd61, 12'd64, 12'd66, 12'd69, 12'd72, 12'd75, 12'd77, 12'd80,
    12'd83, 12'd87, 12'd90, 12'd93, 12'd96, 12'd100, 12'd103, 12'd107,
    12'd111, 12'd115, 12'd118, 12'd122, 12'd126, 12'd131, 12'd135, 12'd139,
    12'd144, 12'd148, 12'd153, 12'd157, 12'd162, 12'd167, 12'd172, 12'd177,
    12'd182, 12'd187, 12'd193, 12'd198, 12'd204, 12'd209, 12'd215, 12'd221,
    12'd227, 12'd233, 12'd239, 12'd246, 12'd252, 12'd259, 12'd265, 12'd272,
    12'd279, 12'd286, 12'd293, 12'd300, 12'd308, 12'd315, 12'd323, 12'd330,
    12'd338, 12'd346, 12'd354, 12'd362, 12'd371, 12'd379, 12'd388, 12'd396,
    12'd405, 12'd414, 12'd423, 12'd432, 12'd442, 12'd451, 12'd461, 12'd470,
    12'd480, 12'd490, 12'd501, 12'd511, 12'd521, 12'd532, 12'd543, 12'd553,
    12'd564, 12'd576, 12'd587, 12'd598, 12'd610, 12'd622, 12'd634, 12'd646,
    12'd658, 12'd670, 12'd683, 12'd695, 12'd708, 12'd721, 12'd734, 12'd748,
    12'd761, 12'd775, 12'd788, 12'd802, 12'd816, 12'd831, 12'd845, 12'd860,
    12'd874, 12'd889, 12'd904, 12'd920, 12'd935, 12'd951, 12'd966, 12'd982,
    12'd999, 12'd1015, 12'd1031, 12'd1048, 12'd1065, 12'd1082, 12'd1099, 12'd1116,
    12'd1134, 12'd1152, 12'd1170, 12'd1188, 12'd1206, 12'd1224, 12'd1243, 12'd1262,
    12'd1281, 12'd1300, 12'd1320, 12'd1339, 12'd1359, 12'd1379, 12'd1399, 12'd1420,
    12'd1440, 12'd1461, 12'd1482, 12'd1503, 12'd1525, 12'd1546, 12'd1568, 12'd1590,
    12'd1612, 12'd1635, 12'd1657, 12'd1680, 12'd1703, 12'd1726, 12'd1750, 12'd1774,
    12'd1797, 12'd1822, 12'd1846, 12'd1870, 12'd1895, 12'd1920, 12'd1945, 12'd1971,
    12'd1996, 12'd2022, 12'd2048, 12'd2074, 12'd2101, 12'd2128, 12'd2155, 12'd2182,
    12'd2209, 12'd2237, 12'd2265, 12'd2293, 12'd2321, 12'd2350, 12'd2378, 12'd2407,
    12'd2437, 12'd2466, 12'd2496, 12'd2526, 12'd2556, 12'd2587, 12'd2617, 12'd2648,
    12'd2679, 12'd2711, 12'd2743, 12'd2774, 12'd2807, 12'd2839, 12'd2872, 12'd2905,
    12'd2938, 12'd2971, 12'd3005, 12'd3039, 12'd3073, 12'd3107, 12'd3142, 12'd3177,
    12'd3212, 12'd3248, 12'd3283, 12'd3319, 12'd3356, 12'd3392, 12'd3429, 12'd3466,
    12'd3503, 12'd3541, 12'd3578, 12'd3617, 12'd3655, 12'd3694, 12'd3732, 12'd3772,
    12'd3811, 12'd3851, 12'd3891, 12'd3931, 12'd3972, 12'd4012, 12'd4054, 12'd4095
  };

endpackage

// ===== hw/rtl/gtd_lane.sv =====
// One color channel: table lookup, residue store, add, clamp, split.
// Depends on gtd_pkg.
module gtd_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  gtd_pkg::lane_ctrl_t         ctrl,
  input  logic [gtd_pkg::CHAN_W-1:0]  chan_byte,
  output gtd_pkg::chan_t              dith
);

  logic [gtd_pkg::RES_W-1:0]  res_mem [gtd_pkg::NUM_PIXELS];

  // stage 1 payload
  logic [gtd_pkg::LUT_W-1:0]  lut_q;
  logic [gtd_pkg::RES_AW-1:0] addr_q;
  logic                       ok_q;
  logic [gtd_pkg::RES_W-1:0]  rdata;

  // last residue written; covers a read issued on the same edge as the write
  logic                       byp_valid;
  logic [gtd_pkg::RES_AW-1:0] byp_addr;
  logic [gtd_pkg::RES_W-1:0]  byp_data;

  logic [gtd_pkg::RES_W-1:0]  res_cur;
  logic [gtd_pkg::LUT_W:0]    sum;
  logic [gtd_pkg::LUT_W-1:0]  clamped;
  logic [gtd_pkg::RES_W-1:0]  res_new;
  logic                       we;
  logic [gtd_pkg::RES_AW-1:0] waddr;
  logic [gtd_pkg::RES_W-1:0]  wdata;

  always_comb begin
    if (!ok_q) begin
      res_cur = '0;
    end else if (byp_valid && (byp_addr == addr_q)) begin
      res_cur = byp_data;
    end else begin
      res_cur = rdata;
    end
    sum     = {1'b0, lut_q} + {{(gtd_pkg::LUT_W + 1 - gtd_pkg::RES_W){1'b0}}, res_cur};
    clamped = sum[gtd_pkg::LUT_W] ? gtd_pkg::LUT_MAX : sum[gtd_pkg::LUT_W-1:0];
    res_new = clamped[gtd_pkg::RES_W-1:0];
    dith    = clamped[gtd_pkg::LUT_W-1:gtd_pkg::RES_W];
  end

  // clearing pass and pipeline writes never overlap
  always_comb begin
    we    = ctrl.clr_we || (ctrl.advance && ok_q);
    waddr = ctrl.clr_we ? ctrl.clr_addr : addr_q;
    wdata = ctrl.clr_we ? '0 : res_new;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      res_mem[waddr] <= wdata;
    end
    if (ctrl.accept) begin
      rdata <= res_mem[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      lut_q  <= gtd_pkg::LIGHT_ROM[chan_byte];
      addr_q <= ctrl.rd_addr;
      ok_q   <= ctrl.rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (ctrl.advance && ok_q) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && ok_q) begin
      byp_addr <= addr_q;
      byp_data <= res_new;
    end
  end

endmodule

// ===== hw/rtl/gtd_merge.sv =====
// Output register: packs the three lane results in the order mode selects.
// Depends on gtd_pkg.
module gtd_merge (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          mode,
  input  gtd_pkg::chan_t [gtd_pkg::LANES-1:0] dith,
  output logic [gtd_pkg::PACKED_W-1:0]  packed_color
);

  logic [gtd_pkg::PACKED_W-1:0] packed_next;

  always_comb begin
    if (mode == gtd_pkg::MODE_HI_TOP) begin
      packed_next = {dith[gtd_pkg::LANE_HI], dith[gtd_pkg::LANE_MID], dith[gtd_pkg::LANE_LO]};
    end else begin
      packed_next = {dith[gtd_pkg::LANE_LO], dith[gtd_pkg::LANE_MID], dith[gtd_pkg::LANE_HI]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packed_color <= packed_next;
    end
  end

endmodule

// ===== hw/rtl/gamma_temporal_dither.sv =====
// Top level of gamma_temporal_dither: handshake control, residue clearing pass,
// three channel lanes and the packing stage. Depends on gtd_pkg, gtd_lane,
// gtd_merge and gamma_temporal_dither_defines.svh.
//
//  channel | dir | beat fields (tdata / tuser, lowest bit first)
//  --------+-----+-------------------------------------------------------------
//  s_*     | in  | tdata: pixel_index[11:0], color_word[35:12], zero[39:36];
//          |     | tuser: mode
//  m_*     | out | tdata: packed_color[29:0], zero[31:30]
//
// One beat per clock sustained while m_tready stays high; an accepted beat is
// registered into stage 1 (lookup + residue read), then goes through add/clamp
// into the output register, which drives m_tdata.
// The residue stores are single-write-port RAMs; a write and a read of the same
// pixel on one edge are resolved by a one-entry bypass in each lane.
// After rst the stores are zeroed by a pass over all NUM_PIXELS entries (4096),
// one entry per cycle; s_tready stays low until it finishes.
// m_tready low holds the output register and stage 1; s_tready drops only
// when both are full and m_tready is low, or while the clearing pass runs.
`include "gamma_temporal_dither_defines.svh"

module gamma_temporal_dither (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gtd_pkg::IN_TDATA_W-1:0]    s_tdata,  // pixel_index, color_word
  input  logic                              s_tuser,  // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gtd_pkg::OUT_TDATA_W-1:0]   m_tdata   // packed_color
);

  localparam logic [gtd_pkg::RES_AW-1:0] CLR_LAST = gtd_pkg::RES_AW'(gtd_pkg::NUM_PIXELS - 1);

  logic                            clear_busy;
  logic [gtd_pkg::RES_AW-1:0]      clr_addr;
  logic                            s1_valid;
  logic                            s1_mode;
  logic                            out_valid;
  logic                            out_free;
  logic                            accept;
  logic                            advance;

  logic [gtd_pkg::IDX_W-1:0]       pixel_index;
  logic [gtd_pkg::COLOR_W-1:0]     color_word;
  logic [gtd_pkg::IDX_EXT_W-1:0]   idx_ext;
  logic [gtd_pkg::PACKED_W-1:0]    packed_color;

  gtd_pkg::lane_ctrl_t             lane_ctrl;
  gtd_pkg::chan_t [gtd_pkg::LANES-1:0] dith;

  assign pixel_index = s_tdata[gtd_pkg::IDX_W-1:0];
  assign color_word  = s_tdata[gtd_pkg::IDX_W +: gtd_pkg::COLOR_W];
  assign idx_ext     = {{(gtd_pkg::IDX_EXT_W - gtd_pkg::IDX_W){1'b0}}, pixel_index};

  // output register frees up when empty or being drained
  assign out_free = !out_valid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !clear_busy && (!s1_valid || out_free);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    lane_ctrl.accept   = accept;
    lane_ctrl.advance  = advance;
    lane_ctrl.rd_addr  = idx_ext[gtd_pkg::RES_AW-1:0];
    lane_ctrl.rd_ok    = idx_ext < gtd_pkg::IDX_EXT_W'(gtd_pkg::NUM_PIXELS);
    lane_ctrl.clr_we   = clear_busy;
    lane_ctrl.clr_addr = clr_addr;
  end

  // zeroing sweep over the residue stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == CLR_LAST) begin
        clear_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // stage 1 and output occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= s_tuser;
    end
  end

  for (genvar i = 0; i < gtd_pkg::LANES; i++) begin : g_lane
    gtd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl),
      .chan_byte (color_word[gtd_pkg::CHAN_W*i +: gtd_pkg::CHAN_W]),
      .dith      (dith[i])
    );
  end

  gtd_merge u_merge (
    .clk          (clk),
    .load         (advance),
    .mode         (s1_mode),
    .dith         (dith),
    .packed_color (packed_color)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(gtd_pkg::OUT_TDATA_W - gtd_pkg::PACKED_W){1'b0}}, packed_color};

  `GTD_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "accepted beat missing from stage 1")
  `GTD_ASSERT_NEXT(a_s1_holds, s1_valid && !out_free, s1_valid, "stalled stage 1 beat lost")
  `GTD_ASSERT_NOW(a_clear_empty, clear_busy, !s1_valid && !out_valid, "beat in flight during clear")
  `GTD_ASSERT_NOW(a_clear_len, $fell(clear_busy), $past(clr_addr) == CLR_LAST, "clear pass cut short")

endmodule
